FILE: rtl/core/car_pkg.sv
// ----------------------------------------------------------------------------
// car_pkg
// Shared constants, codes and item types of the complex arithmetic unit.
// ----------------------------------------------------------------------------
`default_nettype none

package car_pkg;

  // default number of fraction bits of the fixed-point operands
  localparam int FRAC_BITS_DEF = 16;

  // quotient bits produced by the divider (one per pipeline step)
  localparam int QBITS = 33;

  // square root steps for a 64-bit radicand (two bits per step)
  localparam int SQ_STEPS = 32;

  // operation codes
  localparam logic [2:0] ACT_ADD = 3'd0;
  localparam logic [2:0] ACT_SUB = 3'd1;
  localparam logic [2:0] ACT_MUL = 3'd2;
  localparam logic [2:0] ACT_DIV = 3'd3;
  localparam logic [2:0] ACT_MAG = 3'd4;

  // status codes
  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_SAT = 2'd1;
  localparam logic [1:0] ST_DZ  = 2'd2;

  // classified item, operands in sign-magnitude form
  typedef struct packed {
    logic [2:0]  act;
    logic [31:0] ar;
    logic [31:0] ai;
    logic [31:0] br;
    logic [31:0] bi;
    logic        nar;
    logic        nai;
    logic        nbr;
    logic        nbi;
    logic        fr;   // sign of b_real as added (flipped for subtract)
    logic        fi;   // sign of b_imag as added (flipped for subtract)
  } car_item_t;

  // side information riding along the divider / root pipeline
  typedef struct packed {
    logic [2:0]  act;
    logic        re_n;
    logic        im_n;
    logic        dz;
    logic [31:0] fast_re;
    logic [31:0] fast_im;
    logic        fast_sat;
  } car_meta_t;

endpackage

`default_nettype wire

FILE: rtl/core/car_front.sv
// ----------------------------------------------------------------------------
// car_front
// Accepts items, splits operands into sign and magnitude and classifies them.
// ----------------------------------------------------------------------------
`default_nettype none

module car_front (
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [2:0]          action,
  input  logic signed [31:0]  a_real,
  input  logic signed [31:0]  a_imag,
  input  logic signed [31:0]  b_real,
  input  logic signed [31:0]  b_imag,
  input  logic                q_ready,
  output logic                push,
  output car_pkg::car_item_t  item
);

  // two's complement to magnitude, -2^31 maps to 2^31
  function automatic logic [31:0] mag32(input logic [31:0] v);
    mag32 = v[31] ? (~v + 32'd1) : v;
  endfunction

  logic is_sub;

  assign in_ready = q_ready;
  assign push     = in_valid && q_ready;
  assign is_sub   = (action == car_pkg::ACT_SUB);

  // classify and split
  always_comb begin
    item.act = action;
    item.ar  = mag32(a_real);
    item.ai  = mag32(a_imag);
    item.br  = mag32(b_real);
    item.bi  = mag32(b_imag);
    item.nar = a_real[31];
    item.nai = a_imag[31];
    item.nbr = b_real[31];
    item.nbi = b_imag[31];
    item.fr  = is_sub ? !b_real[31] : b_real[31];
    item.fi  = is_sub ? !b_imag[31] : b_imag[31];
  end

endmodule

`default_nettype wire

FILE: rtl/core/car_queue.sv
// ----------------------------------------------------------------------------
// car_queue
// Two-entry queue between the front and the back part.
// ----------------------------------------------------------------------------
`default_nettype none

module car_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  car_pkg::car_item_t  push_item,
  output logic                ready,
  input  logic                pop,
  output car_pkg::car_item_t  head,
  output logic                head_valid
);

  car_pkg::car_item_t mem [2];
  logic [1:0] count;
  logic [1:0] count_next;
  logic       wp;
  logic       rp;
  logic       do_push;
  logic       do_pop;

  assign ready      = (count != 2'd2);
  assign head_valid = (count != 2'd0);
  assign head       = mem[rp];
  assign do_push    = push && ready;
  assign do_pop     = pop && head_valid;
  assign count_next = count + {1'b0, do_push} - {1'b0, do_pop};

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
      wp    <= 1'b0;
      rp    <= 1'b0;
    end else begin
      count <= count_next;
      if (do_push) wp <= ~wp;
      if (do_pop) rp <= ~rp;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) mem[wp] <= push_item;
  end

endmodule

`default_nettype wire

FILE: rtl/core/car_iter.sv
// ----------------------------------------------------------------------------
// car_iter
// Pipelined scaled divider (two lanes, one quotient bit per stage) and
// pipelined integer square root (two lanes, one root bit per stage).
// ----------------------------------------------------------------------------
`default_nettype none

module car_iter #(
  parameter int FRAC_BITS = car_pkg::FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                en,
  input  logic [63:0]         re_m,
  input  logic [63:0]         im_m,
  input  logic [63:0]         d,
  input  car_pkg::car_meta_t  meta_in,
  output logic [car_pkg::QBITS-1:0] q_re,
  output logic                ovf_re,
  output logic [car_pkg::QBITS-1:0] q_im,
  output logic                ovf_im,
  output logic [31:0]         root_a,
  output logic [31:0]         root_b,
  output car_pkg::car_meta_t  meta_out
);

  localparam int QW = car_pkg::QBITS;
  localparam int NS = QW + 1;
  localparam int RSH = QW - FRAC_BITS;

  // one restoring division step: {quotient bit, new remainder}
  function automatic logic [64:0] div_step(input logic [63:0] r, input logic nbit,
                                           input logic [63:0] dv);
    logic [64:0] t;
    logic [64:0] diff;
    t    = {r, nbit};
    diff = t - {1'b0, dv};
    if (t >= {1'b0, dv}) div_step = {1'b1, diff[63:0]};
    else                 div_step = {1'b0, t[63:0]};
  endfunction

  // one square root step: {new remainder, new root}
  function automatic logic [65:0] sq_step(input logic [33:0] rem, input logic [1:0] pr,
                                          input logic [31:0] root);
    logic [35:0] t;
    logic [35:0] trial;
    logic [35:0] diff;
    t     = {rem, pr};
    trial = {2'b00, root, 2'b01};
    diff  = t - trial;
    if (t >= trial) sq_step = {diff[33:0], root[30:0], 1'b1};
    else            sq_step = {t[33:0], root[30:0], 1'b0};
  endfunction

  logic [63:0]    dr_re [NS];
  logic [63:0]    dr_im [NS];
  logic [QW-1:0]  nb_re [NS];
  logic [QW-1:0]  nb_im [NS];
  logic [QW-1:0]  qs_re [NS];
  logic [QW-1:0]  qs_im [NS];
  logic           ov_re [NS];
  logic           ov_im [NS];
  logic [63:0]    dd    [NS];
  logic [63:0]    sx_a  [NS];
  logic [63:0]    sx_b  [NS];
  logic [33:0]    sr_a  [NS];
  logic [33:0]    sr_b  [NS];
  logic [31:0]    rt_a  [NS];
  logic [31:0]    rt_b  [NS];
  car_pkg::car_meta_t meta [NS];

  logic [63:0] init_re;
  logic [63:0] init_im;

  assign init_re = re_m >> RSH;
  assign init_im = im_m >> RSH;

  // setup stage: initial remainder is the numerator above the quotient window
  always_ff @(posedge clk) begin
    if (en) begin
      dr_re[0] <= init_re;
      dr_im[0] <= init_im;
      ov_re[0] <= (init_re >= d);
      ov_im[0] <= (init_im >= d);
      nb_re[0] <= QW'(re_m << FRAC_BITS);
      nb_im[0] <= QW'(im_m << FRAC_BITS);
      qs_re[0] <= '0;
      qs_im[0] <= '0;
      dd[0]    <= d;
      sx_a[0]  <= re_m;
      sx_b[0]  <= im_m;
      sr_a[0]  <= '0;
      sr_b[0]  <= '0;
      rt_a[0]  <= '0;
      rt_b[0]  <= '0;
      meta[0]  <= meta_in;
    end
  end

  // iteration stages
  for (genvar k = 1; k < NS; k++) begin : g_stage
    localparam bit DO_SQ = (k <= car_pkg::SQ_STEPS);
    logic [64:0] ds_re;
    logic [64:0] ds_im;
    logic [65:0] ss_a;
    logic [65:0] ss_b;

    assign ds_re = div_step(dr_re[k-1], nb_re[k-1][QW-1], dd[k-1]);
    assign ds_im = div_step(dr_im[k-1], nb_im[k-1][QW-1], dd[k-1]);
    assign ss_a  = sq_step(sr_a[k-1], sx_a[k-1][63:62], rt_a[k-1]);
    assign ss_b  = sq_step(sr_b[k-1], sx_b[k-1][63:62], rt_b[k-1]);

    always_ff @(posedge clk) begin
      if (en) begin
        dr_re[k] <= ds_re[63:0];
        dr_im[k] <= ds_im[63:0];
        qs_re[k] <= {qs_re[k-1][QW-2:0], ds_re[64]};
        qs_im[k] <= {qs_im[k-1][QW-2:0], ds_im[64]};
        nb_re[k] <= {nb_re[k-1][QW-2:0], 1'b0};
        nb_im[k] <= {nb_im[k-1][QW-2:0], 1'b0};
        ov_re[k] <= ov_re[k-1];
        ov_im[k] <= ov_im[k-1];
        dd[k]    <= dd[k-1];
        meta[k]  <= meta[k-1];
        if (DO_SQ) begin
          sx_a[k] <= {sx_a[k-1][61:0], 2'b00};
          sx_b[k] <= {sx_b[k-1][61:0], 2'b00};
          sr_a[k] <= ss_a[65:32];
          sr_b[k] <= ss_b[65:32];
          rt_a[k] <= ss_a[31:0];
          rt_b[k] <= ss_b[31:0];
        end else begin
          sx_a[k] <= sx_a[k-1];
          sx_b[k] <= sx_b[k-1];
          sr_a[k] <= sr_a[k-1];
          sr_b[k] <= sr_b[k-1];
          rt_a[k] <= rt_a[k-1];
          rt_b[k] <= rt_b[k-1];
        end
      end
    end
  end

  assign q_re     = qs_re[NS-1];
  assign q_im     = qs_im[NS-1];
  assign ovf_re   = ov_re[NS-1];
  assign ovf_im   = ov_im[NS-1];
  assign root_a   = rt_a[NS-1];
  assign root_b   = rt_b[NS-1];
  assign meta_out = meta[NS-1];

endmodule

`default_nettype wire

FILE: rtl/core/car_back.sv
// ----------------------------------------------------------------------------
// car_back
// Back part: products, signed sums, divider / root pipeline, saturation and
// the output register. The whole pipeline advances when the output is free.
// ----------------------------------------------------------------------------
`default_nettype none

module car_back #(
  parameter int FRAC_BITS = car_pkg::FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  car_pkg::car_item_t  head,
  input  logic                head_valid,
  output logic                pop,
  output logic [31:0]         out_real,
  output logic [31:0]         out_imag,
  output logic [1:0]          status,
  output logic                out_valid,
  input  logic                out_ready
);

  localparam int QW = car_pkg::QBITS;
  localparam int NS = QW + 1;

  // sign-magnitude add: {sign, magnitude}, zero is positive
  function automatic logic [64:0] sm_add(input logic [63:0] m1, input logic n1,
                                         input logic [63:0] m2, input logic n2);
    logic [63:0] m;
    logic        n;
    if (n1 == n2) begin
      m = m1 + m2;
      n = n1;
    end else if (m1 >= m2) begin
      m = m1 - m2;
      n = n1;
    end else begin
      m = m2 - m1;
      n = n2;
    end
    if (m == 64'd0) n = 1'b0;
    sm_add = {n, m};
  endfunction

  // saturate sign-magnitude to 32 bits: {saturated, value}
  function automatic logic [32:0] sat32(input logic [63:0] m, input logic neg);
    logic [63:0] t;
    t = 64'd0 - m;
    if (!neg) begin
      if (m > 64'h7FFF_FFFF) sat32 = {1'b1, 32'h7FFF_FFFF};
      else                   sat32 = {1'b0, m[31:0]};
    end else begin
      if (m > 64'h8000_0000) sat32 = {1'b1, 32'h8000_0000};
      else                   sat32 = {1'b0, t[31:0]};
    end
  endfunction

  logic adv;
  assign adv = !out_valid || out_ready;
  assign pop = adv && head_valid;

  // stage valid bits
  logic          va;
  logic          vb;
  logic [NS-1:0] v_it;

  always_ff @(posedge clk) begin
    if (rst) begin
      va        <= 1'b0;
      vb        <= 1'b0;
      v_it      <= '0;
      out_valid <= 1'b0;
    end else if (adv) begin
      va        <= head_valid;
      vb        <= va;
      v_it      <= {v_it[NS-2:0], vb};
      out_valid <= v_it[NS-1];
    end
  end

  // stage A: products, product signs, add/subtract
  logic        is_mag;
  logic [31:0] msel0;
  logic [31:0] msel1;
  logic        sr1, sr2, si1, si2;
  logic [64:0] as_re;
  logic [64:0] as_im;

  assign is_mag = (head.act == car_pkg::ACT_MAG);
  assign msel0  = is_mag ? head.ar : head.br;
  assign msel1  = is_mag ? head.ai : head.bi;
  assign as_re  = sm_add({32'd0, head.ar}, head.nar, {32'd0, head.br}, head.fr);
  assign as_im  = sm_add({32'd0, head.ai}, head.nai, {32'd0, head.bi}, head.fi);

  always_comb begin
    unique case (head.act)
      car_pkg::ACT_MUL: begin
        sr1 = head.nar ^ head.nbr;
        sr2 = !(head.nai ^ head.nbi);
        si1 = head.nar ^ head.nbi;
        si2 = head.nai ^ head.nbr;
      end
      car_pkg::ACT_DIV: begin
        sr1 = head.nar ^ head.nbr;
        sr2 = head.nai ^ head.nbi;
        si1 = !(head.nar ^ head.nbi);
        si2 = head.nai ^ head.nbr;
      end
      default: begin
        sr1 = 1'b0;
        sr2 = 1'b0;
        si1 = 1'b0;
        si2 = 1'b0;
      end
    endcase
  end

  logic [63:0] a_p0, a_p1, a_p2, a_p3, a_p4, a_p5;
  logic        a_sr1, a_sr2, a_si1, a_si2;
  logic [2:0]  a_act;
  logic [32:0] a_asr_m;
  logic [32:0] a_asi_m;
  logic        a_asr_n;
  logic        a_asi_n;

  always_ff @(posedge clk) begin
    if (adv) begin
      a_p0    <= head.ar * msel0;
      a_p1    <= head.ai * msel1;
      a_p2    <= head.ar * head.bi;
      a_p3    <= head.ai * head.br;
      a_p4    <= head.br * head.br;
      a_p5    <= head.bi * head.bi;
      a_sr1   <= sr1;
      a_sr2   <= sr2;
      a_si1   <= si1;
      a_si2   <= si2;
      a_act   <= head.act;
      a_asr_m <= as_re[32:0];
      a_asr_n <= as_re[64];
      a_asi_m <= as_im[32:0];
      a_asi_n <= as_im[64];
    end
  end

  // stage B: signed sums of products and divisor
  logic        a_mag;
  logic [64:0] sum_re;
  logic [64:0] sum_im;

  assign a_mag  = (a_act == car_pkg::ACT_MAG);
  assign sum_re = sm_add(a_p0, a_sr1, a_p1, a_sr2);
  assign sum_im = sm_add(a_mag ? a_p4 : a_p2, a_mag ? 1'b0 : a_si1,
                         a_mag ? a_p5 : a_p3, a_mag ? 1'b0 : a_si2);

  logic [63:0] b_re_m;
  logic [63:0] b_im_m;
  logic [63:0] b_d;
  logic        b_re_n;
  logic        b_im_n;
  logic [2:0]  b_act;
  logic [32:0] b_asr_m;
  logic [32:0] b_asi_m;
  logic        b_asr_n;
  logic        b_asi_n;

  always_ff @(posedge clk) begin
    if (adv) begin
      b_re_m  <= sum_re[63:0];
      b_re_n  <= sum_re[64];
      b_im_m  <= sum_im[63:0];
      b_im_n  <= sum_im[64];
      b_d     <= a_p4 + a_p5;
      b_act   <= a_act;
      b_asr_m <= a_asr_m;
      b_asr_n <= a_asr_n;
      b_asi_m <= a_asi_m;
      b_asi_n <= a_asi_n;
    end
  end

  // results that need no iteration are settled before the pipeline
  car_pkg::car_meta_t meta_c;
  logic [32:0] fr_s;
  logic [32:0] fi_s;

  always_comb begin
    unique case (b_act) inside
      car_pkg::ACT_ADD, car_pkg::ACT_SUB: begin
        fr_s = sat32({31'd0, b_asr_m}, b_asr_n);
        fi_s = sat32({31'd0, b_asi_m}, b_asi_n);
      end
      car_pkg::ACT_MUL: begin
        fr_s = sat32(b_re_m >> FRAC_BITS, b_re_n);
        fi_s = sat32(b_im_m >> FRAC_BITS, b_im_n);
      end
      default: begin
        fr_s = 33'd0;
        fi_s = 33'd0;
      end
    endcase
    meta_c.act      = b_act;
    meta_c.re_n     = b_re_n;
    meta_c.im_n     = b_im_n;
    meta_c.dz       = (b_d == 64'd0);
    meta_c.fast_re  = fr_s[31:0];
    meta_c.fast_im  = fi_s[31:0];
    meta_c.fast_sat = fr_s[32] | fi_s[32];
  end

  // divider and square root pipeline
  logic [QW-1:0] q_re;
  logic [QW-1:0] q_im;
  logic          ovf_re;
  logic          ovf_im;
  logic [31:0]   root_a;
  logic [31:0]   root_b;
  car_pkg::car_meta_t meta_z;

  car_iter #(
    .FRAC_BITS (FRAC_BITS)
  ) u_iter (
    .clk      (clk),
    .en       (adv),
    .re_m     (b_re_m),
    .im_m     (b_im_m),
    .d        (b_d),
    .meta_in  (meta_c),
    .q_re     (q_re),
    .ovf_re   (ovf_re),
    .q_im     (q_im),
    .ovf_im   (ovf_im),
    .root_a   (root_a),
    .root_b   (root_b),
    .meta_out (meta_z)
  );

  // final selection and saturation
  logic [32:0] dq_re;
  logic [32:0] dq_im;
  logic [32:0] mg_a;
  logic [32:0] mg_b;
  logic [31:0] out_real_next;
  logic [31:0] out_imag_next;
  logic [1:0]  status_next;

  always_comb begin
    dq_re = ovf_re ? {1'b1, meta_z.re_n ? 32'h8000_0000 : 32'h7FFF_FFFF}
                   : sat32({31'd0, q_re}, meta_z.re_n);
    dq_im = ovf_im ? {1'b1, meta_z.im_n ? 32'h8000_0000 : 32'h7FFF_FFFF}
                   : sat32({31'd0, q_im}, meta_z.im_n);
    mg_a  = sat32({32'd0, root_a}, 1'b0);
    mg_b  = sat32({32'd0, root_b}, 1'b0);
    unique case (meta_z.act) inside
      car_pkg::ACT_ADD, car_pkg::ACT_SUB, car_pkg::ACT_MUL: begin
        out_real_next = meta_z.fast_re;
        out_imag_next = meta_z.fast_im;
        status_next   = meta_z.fast_sat ? car_pkg::ST_SAT : car_pkg::ST_OK;
      end
      car_pkg::ACT_DIV: begin
        if (meta_z.dz) begin
          out_real_next = 32'd0;
          out_imag_next = 32'd0;
          status_next   = car_pkg::ST_DZ;
        end else begin
          out_real_next = dq_re[31:0];
          out_imag_next = dq_im[31:0];
          status_next   = (dq_re[32] | dq_im[32]) ? car_pkg::ST_SAT : car_pkg::ST_OK;
        end
      end
      car_pkg::ACT_MAG: begin
        out_real_next = mg_a[31:0];
        out_imag_next = mg_b[31:0];
        status_next   = (mg_a[32] | mg_b[32]) ? car_pkg::ST_SAT : car_pkg::ST_OK;
      end
      default: begin
        out_real_next = 32'd0;
        out_imag_next = 32'd0;
        status_next   = car_pkg::ST_OK;
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (adv) begin
      out_real <= out_real_next;
      out_imag <= out_imag_next;
      status   <= status_next;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/complex_arithmetic_unit.sv
// ----------------------------------------------------------------------------
// complex_arithmetic_unit: add, subtract, multiply, divide, magnitudes
// Throughput: one item per cycle while the output is not stalled; the
// 33-stage divider and 32-stage root pipe each take one quotient or root bit
// per stage.
// Reset: synchronous, clears queue and pipeline valid bits; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module complex_arithmetic_unit #(
  parameter int FRAC_BITS = car_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         action,
  input  logic signed [31:0] a_real,
  input  logic signed [31:0] a_imag,
  input  logic signed [31:0] b_real,
  input  logic signed [31:0] b_imag,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_real,
  output logic signed [31:0] out_imag,
  output logic [1:0]         status
);

  car_pkg::car_item_t push_item;
  car_pkg::car_item_t head;
  logic push;
  logic q_ready;
  logic pop;
  logic head_valid;

  // front: accept and classify
  car_front u_front (
    .in_valid (in_valid),
    .in_ready (in_ready),
    .action   (action),
    .a_real   (a_real),
    .a_imag   (a_imag),
    .b_real   (b_real),
    .b_imag   (b_imag),
    .q_ready  (q_ready),
    .push     (push),
    .item     (push_item)
  );

  // decoupling queue
  car_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_item  (push_item),
    .ready      (q_ready),
    .pop        (pop),
    .head       (head),
    .head_valid (head_valid)
  );

  // back: compute and deliver
  car_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .out_real   (out_real),
    .out_imag   (out_imag),
    .status     (status),
    .out_valid  (out_valid),
    .out_ready  (out_ready)
  );

endmodule

`default_nettype wire

FILE: rtl/core/car_checker.sv
// ----------------------------------------------------------------------------
// car_checker
// Port-level checks of the complex arithmetic unit, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module car_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_real,
  input logic [31:0] out_imag,
  input logic [1:0]  status
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_real) &&
                                $stable(out_imag) && $stable(status))
    else $error("result changed while stalled");

  // division by zero gives a zero result
  a_dz_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == car_pkg::ST_DZ) |-> (out_real == 32'd0) && (out_imag == 32'd0))
    else $error("division by zero with nonzero result");

  // after reset the queue has room and no result is pending
  a_reset: assert property (@(posedge clk)
    rst |=> in_ready && !out_valid)
    else $error("state not cleared by reset");

  // the queue fills only by an accepted item
  a_fill: assert property (@(posedge clk) disable iff (rst)
    $fell(in_ready) |-> $past(in_valid))
    else $error("input ready dropped without an item");

endmodule

bind complex_arithmetic_unit car_checker u_car_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_real  (out_real),
  .out_imag  (out_imag),
  .status    (status)
);

`default_nettype wire

FILE: sim/tb_complex_arithmetic_unit.sv
// ----------------------------------------------------------------------------
// tb_complex_arithmetic_unit
// Self-checking bench for the complex arithmetic unit: a directed table of
// corner cases, then bursty random traffic against a bit-exact predictor,
// with random back-pressure on the result side.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_complex_arithmetic_unit;

  localparam int FRAC = car_pkg::FRAC_BITS_DEF;
  localparam int N_RANDOM = 1430;
  localparam int CYCLE_LIMIT = 200000;
  localparam logic [2:0] ACT_UNUSED_5 = 3'd5;
  localparam logic [2:0] ACT_UNUSED_6 = 3'd6;
  localparam logic [2:0] ACT_UNUSED = 3'd7;
  localparam logic [31:0] POS_MAX = 32'h7fffffff;
  localparam logic [31:0] NEG_MAX = 32'h80000000;

  typedef struct packed {
    logic [31:0] re;
    logic [31:0] im;
    logic [1:0]  st;
  } cplx_res_t;

  typedef struct {
    logic [2:0]  act;
    logic [31:0] ar, ai, br, bi;
    bit          typed;
    cplx_res_t   res;
  } stim_row_t;

  logic clk, rst;
  logic in_valid, in_ready, out_valid, out_ready;
  logic [2:0] action;
  logic signed [31:0] a_real, a_imag, b_real, b_imag;
  logic signed [31:0] out_real, out_imag;
  logic [1:0] status;

  cplx_res_t pending_results[$];
  int errors = 0;
  int n_checked = 0;
  int n_sent = 0;
  int cycles = 0;
  int act_count[8];

  complex_arithmetic_unit u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .action(action), .a_real(a_real), .a_imag(a_imag),
    .b_real(b_real), .b_imag(b_imag),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_real(out_real), .out_imag(out_imag), .status(status)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // sign-magnitude helpers of the predictor
  function automatic void split_sm(input logic [31:0] v, output bit [63:0] m, output bit n);
    n = v[31];
    m = n ? (64'h1_0000_0000 - {32'd0, v}) : {32'd0, v};
  endfunction

  function automatic void add_sm(input bit [63:0] m1, input bit n1, input bit [63:0] m2,
                                 input bit n2, output bit [63:0] m, output bit n);
    if (n1 == n2) begin
      m = m1 + m2;
      n = n1;
    end else if (m1 >= m2) begin
      m = m1 - m2;
      n = n1;
    end else begin
      m = m2 - m1;
      n = n2;
    end
    if (m == 0) n = 1'b0;
  endfunction

  function automatic logic [31:0] clip32(input bit [63:0] m, input bit n, inout bit sat);
    bit [63:0] t;
    if (!n) begin
      if (m > 64'(POS_MAX)) begin
        sat = 1'b1;
        return POS_MAX;
      end
      return m[31:0];
    end
    if (m > 64'(NEG_MAX)) begin
      sat = 1'b1;
      return NEG_MAX;
    end
    t = 64'd0 - m;
    return t[31:0];
  endfunction

  function automatic bit [63:0] root_floor(input bit [63:0] x);
    bit [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // floor(n * 2^FRAC / d), clipped just above 32 bits
  function automatic bit [63:0] frac_quotient(input bit [63:0] n, input bit [63:0] d);
    bit [63:0] q, r;
    q = n / d;
    r = n % d;
    for (int i = 0; i < FRAC; i++) begin
      if (q > 64'hffff_ffff) return 64'h1_0000_0000;
      q = q << 1;
      r = r << 1;
      if (r >= d) begin
        r = r - d;
        q[0] = 1'b1;
      end
    end
    return (q > 64'hffff_ffff) ? 64'h1_0000_0000 : q;
  endfunction

  // expected result of one item
  function automatic cplx_res_t complex_result(input logic [2:0] act, input logic [31:0] xr,
                                               input logic [31:0] xi, input logic [31:0] yr,
                                               input logic [31:0] yi);
    bit [63:0] ar, ai, br, bi, m, d;
    bit nar, nai, nbr, nbi, n, sat;
    cplx_res_t r;
    sat = 1'b0;
    r = '0;
    r.st = car_pkg::ST_OK;
    split_sm(xr, ar, nar);
    split_sm(xi, ai, nai);
    split_sm(yr, br, nbr);
    split_sm(yi, bi, nbi);
    case (act)
      car_pkg::ACT_ADD, car_pkg::ACT_SUB: begin
        add_sm(ar, nar, br, (act == car_pkg::ACT_SUB) ? !nbr : nbr, m, n);
        r.re = clip32(m, n, sat);
        add_sm(ai, nai, bi, (act == car_pkg::ACT_SUB) ? !nbi : nbi, m, n);
        r.im = clip32(m, n, sat);
      end
      car_pkg::ACT_MUL: begin
        add_sm(ar * br, nar != nbr, ai * bi, !(nai != nbi), m, n);
        r.re = clip32(m >> FRAC, n, sat);
        add_sm(ar * bi, nar != nbi, ai * br, nai != nbr, m, n);
        r.im = clip32(m >> FRAC, n, sat);
      end
      car_pkg::ACT_DIV: begin
        d = br * br + bi * bi;
        if (d == 0) begin
          r.st = car_pkg::ST_DZ;
        end else begin
          add_sm(ar * br, nar != nbr, ai * bi, nai != nbi, m, n);
          r.re = clip32(frac_quotient(m, d), n, sat);
          add_sm(ai * br, nai != nbr, ar * bi, !(nar != nbi), m, n);
          r.im = clip32(frac_quotient(m, d), n, sat);
        end
      end
      car_pkg::ACT_MAG: begin
        r.re = clip32(root_floor(ar * ar + ai * ai), 1'b0, sat);
        r.im = clip32(root_floor(br * br + bi * bi), 1'b0, sat);
      end
      default: ;
    endcase
    if (r.st == car_pkg::ST_OK && sat) r.st = car_pkg::ST_SAT;
    return r;
  endfunction

  // random operand part: mostly moderate values, some extremes and zeros
  function automatic logic [31:0] rand_part();
    int k;
    k = $urandom_range(0, 9);
    case (k)
      0: return $urandom;
      1: return 32'd0;
      2: return ($urandom_range(0, 1) != 0) ? POS_MAX : NEG_MAX;
      3, 4: return 32'($signed($urandom_range(0, 32'h1fffff)) - 32'sh100000);
      default: return 32'($signed($urandom_range(0, 32'h1ffffff)) - 32'sh1000000);
    endcase
  endfunction

  // present one item and hold it until accepted
  task automatic send_item(input logic [2:0] act, input logic [31:0] xr, input logic [31:0] xi,
                           input logic [31:0] yr, input logic [31:0] yi, input bit typed,
                           input cplx_res_t typed_res);
    in_valid = 1'b1;
    action = act;
    a_real = xr;
    a_imag = xi;
    b_real = yr;
    b_imag = yi;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(typed ? typed_res : complex_result(act, xr, xi, yr, yi));
    act_count[act]++;
    n_sent++;
    @(negedge clk);
  endtask

  // stimulus
  initial begin
    stim_row_t dir[$];
    int burst;
    rst = 1'b1;
    in_valid = 1'b0;
    action = car_pkg::ACT_ADD;
    a_real = 0;
    a_imag = 0;
    b_real = 0;
    b_imag = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed corners
    dir.push_back('{car_pkg::ACT_ADD, 0, 0, 0, 0, 1, '{0, 0, car_pkg::ST_OK}});
    dir.push_back('{car_pkg::ACT_ADD, POS_MAX, NEG_MAX, POS_MAX, NEG_MAX, 1,
                    '{POS_MAX, NEG_MAX, car_pkg::ST_SAT}});
    dir.push_back('{car_pkg::ACT_SUB, NEG_MAX, POS_MAX, 1, 32'hffffffff, 1,
                    '{NEG_MAX, POS_MAX, car_pkg::ST_SAT}});
    dir.push_back('{car_pkg::ACT_SUB, POS_MAX, NEG_MAX, POS_MAX, NEG_MAX, 1,
                    '{0, 0, car_pkg::ST_OK}});
    dir.push_back('{car_pkg::ACT_MUL, 32'h10000, 0, 32'h10000, 0, 1,
                    '{32'h10000, 0, car_pkg::ST_OK}});
    dir.push_back('{car_pkg::ACT_MUL, NEG_MAX, NEG_MAX, NEG_MAX, NEG_MAX, 0,
                    '{0, 0, car_pkg::ST_OK}});
    dir.push_back('{car_pkg::ACT_MUL, POS_MAX, 32'hffff8000, 32'h00018000, NEG_MAX, 0,
                    '{0, 0, car_pkg::ST_OK}});
    dir.push_back('{car_pkg::ACT_DIV, 32'h10000, 32'h10000, 0, 0, 1,
                    '{0, 0, car_pkg::ST_DZ}});
    dir.push_back('{car_pkg::ACT_DIV, POS_MAX, NEG_MAX, 0, 0, 1, '{0, 0, car_pkg::ST_DZ}});
    dir.push_back('{car_pkg::ACT_DIV, 32'h10000, 0, 32'hffff0000, 0, 1,
                    '{32'hffff0000, 0, car_pkg::ST_OK}});
    dir.push_back('{car_pkg::ACT_DIV, 32'hfffe0000, 32'h30000, 32'hffff0000, 32'hffff0000, 0,
                    '{0, 0, car_pkg::ST_OK}});
    dir.push_back('{car_pkg::ACT_DIV, POS_MAX, POS_MAX, 0, 1, 0, '{0, 0, car_pkg::ST_OK}});
    dir.push_back('{car_pkg::ACT_DIV, NEG_MAX, NEG_MAX, NEG_MAX, NEG_MAX, 0,
                    '{0, 0, car_pkg::ST_OK}});
    dir.push_back('{car_pkg::ACT_MAG, 32'h30000, 32'hfffc0000, 0, 0, 1,
                    '{32'h50000, 0, car_pkg::ST_OK}});
    dir.push_back('{car_pkg::ACT_MAG, NEG_MAX, NEG_MAX, POS_MAX, 0, 1,
                    '{POS_MAX, POS_MAX, car_pkg::ST_SAT}});
    dir.push_back('{car_pkg::ACT_MAG, NEG_MAX, 0, 1, 1, 0, '{0, 0, car_pkg::ST_OK}});
    dir.push_back('{ACT_UNUSED_5, POS_MAX, POS_MAX, NEG_MAX, NEG_MAX, 1,
                    '{0, 0, car_pkg::ST_OK}});
    dir.push_back('{ACT_UNUSED_6, 1, 1, 1, 1, 1, '{0, 0, car_pkg::ST_OK}});
    dir.push_back('{ACT_UNUSED, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff, 1,
                    '{0, 0, car_pkg::ST_OK}});
    foreach (dir[i])
      send_item(dir[i].act, dir[i].ar, dir[i].ai, dir[i].br, dir[i].bi, dir[i].typed,
                dir[i].res);

    // random traffic in bursts
    while (n_sent < dir.size() + N_RANDOM) begin
      burst = $urandom_range(1, 24);
      repeat (burst)
        send_item(($urandom_range(0, 15) == 0) ? 3'($urandom_range(5, 7))
                                               : 3'($urandom_range(0, 4)),
                  rand_part(), rand_part(), rand_part(), rand_part(), 0, '0);
      if ($urandom_range(0, 3) != 0) begin
        in_valid = 1'b0;
        repeat ($urandom_range(1, 8)) @(negedge clk);
      end
    end
    in_valid = 1'b0;

    // drain
    while (pending_results.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    $display("%0d items sent, %0d results checked, %0d mismatches", n_sent, n_checked, errors);
    $display("per action: add %0d sub %0d mul %0d div %0d mag %0d unused %0d",
             act_count[0], act_count[1], act_count[2], act_count[3], act_count[4],
             act_count[5] + act_count[6] + act_count[7]);
    if (errors == 0 && pending_results.size() == 0)
      $display("** complex_arithmetic_unit: PASSED **");
    else
      $display("** complex_arithmetic_unit: FAILED **");
    $finish;
  end

  // result side back-pressure: modes of random length
  initial begin
    int mode;
    out_ready = 1'b0;
    forever begin
      mode = $urandom_range(0, 3);
      repeat ($urandom_range(10, 80)) begin
        @(negedge clk);
        case (mode)
          0: out_ready = 1'b1;
          1: out_ready = ($urandom_range(0, 1) != 0);
          2: out_ready = ($urandom_range(0, 7) == 0);
          default: out_ready = ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  // result check
  always @(posedge clk) begin
    cplx_res_t e;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected item: re %h im %h st %0d", out_real, out_imag, status);
      end else begin
        e = pending_results.pop_front();
        n_checked++;
        if (out_real !== e.re || out_imag !== e.im || status !== e.st) begin
          errors++;
          if (errors <= 10)
            $display("mismatch on item %0d: exp re %h im %h st %0d, got re %h im %h st %0d",
                     n_checked, e.re, e.im, e.st, out_real, out_imag, status);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("** complex_arithmetic_unit: FAILED **");
      $finish;
    end
  end

endmodule
